### hdl/cltok_pkg.sv
// ----------------------------------------------------------------------------
// Command-line tokenizer package
// Beat types, result kinds, character classes and the tokenizer state record.
// ----------------------------------------------------------------------------
package cltok_pkg;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic {
        ACT_BYTE  = 1'b0,
        ACT_FLUSH = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_TEND = 2'd1,
        KIND_EOL  = 2'd2
    } kind_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] in_byte;
    } tok_in_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        logic       last_of_run;
    } tok_out_t;

    typedef struct packed {
        logic       escape_pending;
        logic       inside_quotes;
        logic [7:0] open_quote_char;
        logic       token_was_quoted;
        logic       token_has_chars;
    } tok_state_t;

    // Results of one input beat: count of valid results and the results.
    typedef struct packed {
        logic [1:0] count;
        tok_out_t   item0;
        tok_out_t   item1;
    } tok_step_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h0A) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0C);
    endfunction

    function automatic logic is_quote(input logic [7:0] b);
        return (b == CH_SQUOTE) || (b == CH_DQUOTE);
    endfunction

    function automatic tok_out_t make_item(input kind_t k, input logic [7:0] b,
                                           input logic last);
        tok_out_t r;
        r.kind        = k;
        r.out_byte    = b;
        r.last_of_run = last;
        return r;
    endfunction

endpackage

### hdl/command_line_tokenizer.sv
// Results of an accepted beat are registered in the result queue and offered in order.
// One input beat per cycle is accepted while each beat yields at most one result and
// results are not stalled; two-result beats leave one at a time by the single output port.
// Input stalls while the four-entry result queue has fewer than two free entries.
// Reset clears all tokenizer flags and empties the result queue.
// ----------------------------------------------------------------------------
// Command-line tokenizer
// Splits a shell-style command-line byte stream into token characters,
// token ends and end-of-line marks.
// ----------------------------------------------------------------------------
module command_line_tokenizer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  cltok_pkg::tok_in_t  src_data,
    output logic                tok_valid,
    input  logic                tok_stall,
    output cltok_pkg::tok_out_t tok_data
);
    import cltok_pkg::*;

    tok_state_t          state_reg;
    tok_state_t          state_next;
    tok_step_t           step;
    tok_out_t            queue_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                push;
    logic                pop;
    logic [QPTR_W-1:0]   wr_ptr1;

    cltok_step u_step (
        .cur  (state_reg),
        .data (src_data),
        .nxt  (state_next),
        .res  (step)
    );

    // A beat is accepted only while the queue has room for the two results of the worst-case beat.
    assign src_stall = (count_reg > QCNT_W'(QDEPTH - 2));
    assign push      = src_valid & ~src_stall;
    assign tok_valid = (count_reg != '0);
    assign pop       = tok_valid & ~tok_stall;
    assign tok_data  = queue_reg[rd_ptr_reg];
    assign wr_ptr1   = wr_ptr_reg + QPTR_W'(1);

    always_comb
    begin
        count_next = count_reg;
        if (push)
        begin
            count_next = count_next + QCNT_W'(step.count);
        end
        if (pop)
        begin
            count_next = count_next - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                state_reg  <= state_next;
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(step.count);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && step.count != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= step.item0;
        end
        if (push && step.count == 2'd2)
        begin
            queue_reg[wr_ptr1] <= step.item1;
        end
    end

endmodule

### hdl/cltok_step.sv
// ----------------------------------------------------------------------------
// Command-line tokenizer step logic
// Decodes one input beat against the current flags into the next flags and
// up to two result beats.
// ----------------------------------------------------------------------------
module cltok_step (
    input  cltok_pkg::tok_state_t cur,
    input  cltok_pkg::tok_in_t    data,
    output cltok_pkg::tok_state_t nxt,
    output cltok_pkg::tok_step_t  res
);
    import cltok_pkg::*;

    logic       pending;
    logic [7:0] b;

    assign b       = data.in_byte;
    assign pending = cur.token_has_chars | cur.token_was_quoted;

    always_comb
    begin
        nxt       = cur;
        res.count = 2'd0;
        res.item0 = make_item(KIND_CHAR, 8'h00, 1'b0);
        res.item1 = make_item(KIND_CHAR, 8'h00, 1'b0);

        priority if (data.action == ACT_FLUSH)
        begin
            nxt = '0;
            if (pending)
            begin
                res.count = 2'd2;
                res.item0 = make_item(KIND_TEND, 8'h00, 1'b0);
                res.item1 = make_item(KIND_EOL, 8'h00, 1'b1);
            end
            else
            begin
                res.count = 2'd1;
                res.item0 = make_item(KIND_EOL, 8'h00, 1'b1);
            end
        end
        else if (!cur.escape_pending && b == CH_BSLASH)
        begin
            nxt.escape_pending = 1'b1;
        end
        else if (cur.escape_pending)
        begin
            nxt.escape_pending  = 1'b0;
            nxt.token_has_chars = 1'b1;
            // Escaped whitespace and quotes lose their backslash.
            if (!is_space(b) && !is_quote(b))
            begin
                res.count = 2'd2;
                res.item0 = make_item(KIND_CHAR, CH_BSLASH, 1'b0);
                res.item1 = make_item(KIND_CHAR, b, 1'b1);
            end
            else
            begin
                res.count = 2'd1;
                res.item0 = make_item(KIND_CHAR, b, 1'b1);
            end
        end
        else if (cur.inside_quotes)
        begin
            if (b == cur.open_quote_char)
            begin
                nxt.inside_quotes = 1'b0;
            end
            else
            begin
                nxt.token_has_chars = 1'b1;
                res.count = 2'd1;
                res.item0 = make_item(KIND_CHAR, b, 1'b1);
            end
        end
        else if (is_quote(b))
        begin
            nxt.inside_quotes    = 1'b1;
            nxt.open_quote_char  = b;
            nxt.token_was_quoted = 1'b1;
        end
        else if (is_space(b))
        begin
            nxt.token_has_chars  = 1'b0;
            nxt.token_was_quoted = 1'b0;
            if (pending)
            begin
                res.count = 2'd1;
                res.item0 = make_item(KIND_TEND, 8'h00, 1'b1);
            end
        end
        else
        begin
            nxt.token_has_chars = 1'b1;
            res.count = 2'd1;
            res.item0 = make_item(KIND_CHAR, b, 1'b1);
        end
    end

endmodule

### hdl/cltok_checker.sv
// ----------------------------------------------------------------------------
// Command-line tokenizer checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module cltok_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                src_valid,
    input logic                src_stall,
    input cltok_pkg::tok_in_t  src_data,
    input logic                tok_valid,
    input logic                tok_stall,
    input cltok_pkg::tok_out_t tok_data
);
    import cltok_pkg::*;

    // An accepted input beat carries known bits.
    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src_stall |-> !$isunknown(src_data))
        else $error("accepted input beat has unknown bits");

    // A stalled result beat stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_stall |=> tok_valid && $stable(tok_data))
        else $error("stalled result beat changed");

    // An end-of-line mark always closes the run of its flush beat.
    a_eol_last: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_data.kind == KIND_EOL |-> tok_data.last_of_run)
        else $error("end of line not marked last");

    // Only token characters carry a byte.
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_data.kind != KIND_CHAR |-> tok_data.out_byte == 8'h00)
        else $error("non-character result carries a byte");

    // A token end that is not last of its run is always the first half of a flush.
    a_tend_pair: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_stall && tok_data.kind == KIND_TEND && !tok_data.last_of_run
        |=> tok_valid && tok_data.kind == KIND_EOL)
        else $error("token end without following end of line");

endmodule

bind command_line_tokenizer cltok_checker u_cltok_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_data  (tok_data)
);
